// ----- rtl/core/connection_innovation_table_defines.svh -----
// Assertion macros used by the checker file.
`ifndef CONNECTION_INNOVATION_TABLE_DEFINES_SVH
`define CONNECTION_INNOVATION_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CIT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("connection_innovation_table: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CIT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("connection_innovation_table: next-cycle check failed");

`endif

// ----- rtl/core/cit_pkg.sv -----
package cit_pkg;

	// field widths
	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 12;
	localparam int NODE_IN_W = 10;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 11;
	localparam int REG_W    = 10;

	// node numbers as held in the table; a node total never exceeds 3070
	localparam int NODE_W     = 12;
	localparam int MAX_NODES  = 1024;
	localparam int TOTAL_MAX  = 2047;
	localparam int HIDDEN_MAX = 1023;

	// slave tdata: gene_index, source_node, target_node
	localparam int IN_GIDX_LSB = 0;
	localparam int IN_SRC_LSB  = IN_GIDX_LSB + INDEX_W;
	localparam int IN_TGT_LSB  = IN_SRC_LSB + NODE_IN_W;
	localparam int S_TDATA_W   = 32;

	// master tdata: found_existing, first_index, second_index,
	// gene_source, gene_target, total_nodes
	localparam int OUT_FOUND_LSB  = 0;
	localparam int OUT_FIRST_LSB  = OUT_FOUND_LSB + 1;
	localparam int OUT_SECOND_LSB = OUT_FIRST_LSB + INDEX_W;
	localparam int OUT_GSRC_LSB   = OUT_SECOND_LSB + INDEX_W;
	localparam int OUT_GTGT_LSB   = OUT_GSRC_LSB + NODE_IN_W;
	localparam int OUT_TOTAL_LSB  = OUT_GTGT_LSB + NODE_IN_W;
	localparam int M_TDATA_W      = 56;

	localparam logic [FUNC_W-1:0] FUNC_ADD_CONN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD_NODE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT     = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_IDX  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

	localparam logic [2:0] ADDR_SENSOR_COUNT = 3'd0;
	localparam logic [2:0] ADDR_OUTPUT_COUNT = 3'd4;

endpackage

// ----- rtl/core/connection_innovation_table.sv -----
// Each function takes its own path: read fetches the entry at gene_index, add node
// reads the split entry and writes two new genes, initialize writes (sensor_count + 1) *
// output_count genes, and add connection walks the table one entry a cycle through the single table read port.
// One item is in work at a time; the next is taken once the result is registered.
// Reset (arst_n low, asynchronous) clears the registers, gene and hidden counts and
// handshakes; table contents are not cleared and are only read below the gene count.
module connection_innovation_table #(
	parameter int MAX_GENES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// gene_index [11:0], source_node [21:12], target_node [31:22]
	input  logic [cit_pkg::S_TDATA_W-1:0]   s_tdata,
	// func [1:0]
	input  logic [cit_pkg::FUNC_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// found_existing [0], first_index [12:1], second_index [24:13],
	// gene_source [34:25], gene_target [44:35], total_nodes [55:45]
	output logic [cit_pkg::M_TDATA_W-1:0]   m_tdata,
	// status [1:0]
	output logic [cit_pkg::STATUS_W-1:0]    m_tuser
);

	import cit_pkg::*;

	localparam int IDX_W  = $clog2(MAX_GENES);
	localparam int CNT_W  = $clog2(MAX_GENES + 1);
	localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam int GENE_W = 2 * NODE_W;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SEARCH    = 4'd1;
	localparam logic [3:0] ST_SPLIT_RD  = 4'd2;
	localparam logic [3:0] ST_SPLIT_W1  = 4'd3;
	localparam logic [3:0] ST_SPLIT_W2  = 4'd4;
	localparam logic [3:0] ST_INIT_CHK  = 4'd5;
	localparam logic [3:0] ST_FILL      = 4'd6;
	localparam logic [3:0] ST_READ_RD   = 4'd7;
	localparam logic [3:0] ST_READ_TAKE = 4'd8;
	localparam logic [3:0] ST_FINISH    = 4'd9;

	logic [3:0]           state_q;
	logic [REG_W-1:0]     sensor_q, output_q;
	logic [CNT_W-1:0]     count_q;
	logic [REG_W-1:0]     hidden_q;

	logic [INDEX_W-1:0]   gidx_q;
	logic [NODE_IN_W-1:0] src_q, tgt_q;
	logic [NODE_W-1:0]    total_q;
	logic [NODE_W-1:0]    t0_q;
	logic [REG_W-1:0]     fill_s_q;
	logic [NODE_W-1:0]    fill_o_q;
	logic [CNT_W-1:0]     issue_q;
	logic                 pend_s1;
	logic [CNT_W-1:0]     idx_s1;

	logic [STATUS_W-1:0]  status_q;
	logic                 found_q;
	logic [INDEX_W-1:0]   first_q, second_q;
	logic [NODE_IN_W-1:0] gsrc_q, gtgt_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]  m_tuser_q;

	logic [INDEX_W-1:0]   in_gidx;
	logic [NODE_IN_W-1:0] in_src, in_tgt;
	logic [NODE_W-1:0]    tot_now;
	logic [TOTAL_W-1:0]   tot_sat;
	logic                 accept, reject, gidx_bad, node_full;
	logic [20:0]          init_prod;
	logic                 init_bad;
	logic [GENE_W-1:0]    key;
	logic                 hit_now, more, table_full, fill_last;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr, rd_addr;
	logic [GENE_W-1:0]    wr_data, rd_data;

	cit_ram #(
		.WIDTH(GENE_W),
		.DEPTH(MAX_GENES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? {22'd0, output_q} : {22'd0, sensor_q};
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign in_gidx = s_tdata[IN_GIDX_LSB +: INDEX_W];
	assign in_src  = s_tdata[IN_SRC_LSB +: NODE_IN_W];
	assign in_tgt  = s_tdata[IN_TGT_LSB +: NODE_IN_W];

	assign tot_now = NODE_W'(1) + NODE_W'(sensor_q) + NODE_W'(output_q) + NODE_W'(hidden_q);
	assign tot_sat = (tot_now > NODE_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(tot_now);

	assign reject   = (in_tgt <= sensor_q) || (NODE_W'(in_tgt) >= tot_now) ||
			(NODE_W'(in_src) >= tot_now);
	assign gidx_bad = CMP_W'(in_gidx) >= CMP_W'(count_q);
	assign node_full = (32'(tot_now) >= 32'(MAX_NODES)) ||
			(hidden_q == REG_W'(HIDDEN_MAX)) ||
			(32'(count_q) + 32'd2 > 32'(MAX_GENES));

	assign init_prod = (21'(sensor_q) + 21'd1) * 21'(output_q);
	assign init_bad  = (32'(tot_now) > 32'(MAX_NODES)) || (32'(init_prod) > 32'(MAX_GENES));

	// search key: target in the upper half, source in the lower
	assign key        = {NODE_W'(tgt_q), NODE_W'(src_q)};
	assign hit_now    = pend_s1 && (rd_data == key);
	assign more       = issue_q < count_q;
	assign table_full = 32'(count_q) >= 32'(MAX_GENES);
	assign fill_last  = fill_o_q == (tot_now - NODE_W'(1));

	always_comb begin
		rd_addr = (state_q == ST_SEARCH) ? IDX_W'(issue_q) : IDX_W'(gidx_q);
		wr_addr = IDX_W'(count_q);
		wr_en   = 1'b0;
		wr_data = key;
		case (state_q)
			ST_SEARCH: begin
				wr_en = !hit_now && !more && !pend_s1 && !table_full;
			end
			ST_SPLIT_W1: begin
				wr_en   = 1'b1;
				wr_data = {total_q, rd_data[NODE_W-1:0]};
			end
			ST_SPLIT_W2: begin
				wr_en   = 1'b1;
				wr_data = {t0_q, total_q};
			end
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_data = {fill_o_q, NODE_W'(fill_s_q)};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_q <= '0;
			output_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				output_q <= pwdata[REG_W-1:0];
			end else begin
				sensor_q <= pwdata[REG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			hidden_q   <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// the finish state drives valid itself
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						gidx_q   <= in_gidx;
						src_q    <= in_src;
						tgt_q    <= in_tgt;
						total_q  <= tot_now;
						found_q  <= 1'b0;
						first_q  <= '0;
						second_q <= '0;
						gsrc_q   <= '0;
						gtgt_q   <= '0;
						case (s_tuser)
							FUNC_ADD_CONN: begin
								issue_q <= '0;
								pend_s1 <= 1'b0;
								if (reject) begin
									status_q <= STATUS_REJECTED;
									state_q  <= ST_FINISH;
								end else begin
									status_q <= STATUS_OK;
									state_q  <= ST_SEARCH;
								end
							end
							FUNC_ADD_NODE: begin
								if (gidx_bad) begin
									status_q <= STATUS_BAD_IDX;
									state_q  <= ST_FINISH;
								end else if (node_full) begin
									status_q <= STATUS_FULL;
									state_q  <= ST_FINISH;
								end else begin
									status_q <= STATUS_OK;
									state_q  <= ST_SPLIT_RD;
								end
							end
							FUNC_INIT: begin
								status_q <= STATUS_OK;
								count_q  <= '0;
								hidden_q <= '0;
								state_q  <= ST_INIT_CHK;
							end
							default: begin
								if (gidx_bad) begin
									status_q <= STATUS_BAD_IDX;
									state_q  <= ST_FINISH;
								end else begin
									status_q <= STATUS_OK;
									state_q  <= ST_READ_RD;
								end
							end
						endcase
					end
				end
				ST_SEARCH: begin
					// compare the entry read last cycle while the next read is issued
					if (hit_now) begin
						found_q <= 1'b1;
						first_q <= INDEX_W'(idx_s1);
						pend_s1 <= 1'b0;
						state_q <= ST_FINISH;
					end else if (more) begin
						pend_s1 <= 1'b1;
						idx_s1  <= issue_q;
						issue_q <= issue_q + CNT_W'(1);
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						if (table_full) begin
							status_q <= STATUS_FULL;
						end else begin
							first_q <= INDEX_W'(count_q);
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_FINISH;
					end
				end
				ST_SPLIT_RD: begin
					state_q <= ST_SPLIT_W1;
				end
				ST_SPLIT_W1: begin
					t0_q    <= rd_data[GENE_W-1:NODE_W];
					first_q <= INDEX_W'(count_q);
					count_q <= count_q + CNT_W'(1);
					state_q <= ST_SPLIT_W2;
				end
				ST_SPLIT_W2: begin
					second_q <= INDEX_W'(count_q);
					count_q  <= count_q + CNT_W'(1);
					hidden_q <= hidden_q + REG_W'(1);
					state_q  <= ST_FINISH;
				end
				ST_INIT_CHK: begin
					fill_s_q <= '0;
					fill_o_q <= NODE_W'(sensor_q) + NODE_W'(1);
					if (init_bad) begin
						status_q <= STATUS_FULL;
						state_q  <= ST_FINISH;
					end else if (output_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					count_q <= count_q + CNT_W'(1);
					if (fill_last) begin
						fill_o_q <= NODE_W'(sensor_q) + NODE_W'(1);
						fill_s_q <= fill_s_q + REG_W'(1);
						if (fill_s_q == sensor_q) begin
							state_q <= ST_FINISH;
						end
					end else begin
						fill_o_q <= fill_o_q + NODE_W'(1);
					end
				end
				ST_READ_RD: begin
					state_q <= ST_READ_TAKE;
				end
				ST_READ_TAKE: begin
					gsrc_q  <= rd_data[NODE_IN_W-1:0];
					gtgt_q  <= rd_data[NODE_W +: NODE_IN_W];
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && (!m_tvalid_q || m_tready)) begin
			m_tuser_q <= status_q;
			m_tdata_q <= {tot_sat, gtgt_q, gsrc_q, second_q, first_q, found_q};
		end
	end

endmodule

// ----- rtl/core/cit_ram.sv -----
module cit_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- rtl/core/cit_checker.sv -----
`include "connection_innovation_table_defines.svh"

module cit_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cit_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [cit_pkg::STATUS_W-1:0]  m_tuser
);

	import cit_pkg::*;

	// a stalled result holds
	`CIT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// one item at a time: no transfer in the cycle after one
	`CIT_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

	// a match is only reported with an ok status
	`CIT_ASSERT_IMP(a_found_ok, m_tvalid && m_tdata[OUT_FOUND_LSB], m_tuser == STATUS_OK)

	// a second gene index only comes from a successful split
	`CIT_ASSERT_IMP(a_second_ok, m_tvalid && (m_tdata[OUT_SECOND_LSB +: INDEX_W] != '0), m_tuser == STATUS_OK && !m_tdata[OUT_FOUND_LSB])

	// the bias node is always counted
	`CIT_ASSERT_IMP(a_total_nonzero, m_tvalid, m_tdata[OUT_TOTAL_LSB +: TOTAL_W] != '0)

endmodule

bind connection_innovation_table cit_checker u_cit_checker (.*);
